FILE: rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int WIN_SIZE_BITS  = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_WINDOW_SIZE  = 2'd0;
  localparam logic [WIN_SIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    restart;
  } in_item_t;

  typedef struct packed {
    sample_t window_min;
    sample_t window_max;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_result;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/swmm_dp.sv
// ----------------------------------------------------------------------------
// swmm_dp
// Datapath: sample ring memory, fill count, scan address counter,
// min/max accumulators and the output register.
// ----------------------------------------------------------------------------
module swmm_dp #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swmm_pkg::dp_cmd_t                   cmd,
  output swmm_pkg::dp_sts_t                   sts,
  input  logic [swmm_pkg::WIN_SIZE_BITS-1:0]  window_size,
  input  swmm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output swmm_pkg::out_item_t                 out_item
);
  import swmm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);
  localparam logic [CW-1:0] FILL_CAP  = CW'(WINDOW_MAX);

  sample_t mem [WINDOW_MAX];

  logic [AW-1:0] wptr_r;
  logic [CW-1:0] fill_r;
  logic [AW-1:0] rd_addr_r;
  logic [CW-1:0] left_r;
  logic          pend_r;
  sample_t       rd_data_r;
  sample_t       lo_r;
  sample_t       hi_r;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic [CW-1:0] eff_k;
  logic [CW-1:0] fill_base;
  logic [CW-1:0] fill_nxt;
  logic [AW-1:0] wptr_inc;
  logic [AW-1:0] wptr_prev;
  logic [AW-1:0] rd_prev;
  logic          rd_en;

  always_comb begin
    if (window_size == '0) begin
      eff_k = CW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      eff_k = FILL_CAP;
    end else begin
      eff_k = CW'(window_size);
    end
  end

  assign fill_base = in_item.restart ? '0 : fill_r;
  assign fill_nxt  = (fill_base < FILL_CAP) ? fill_base + CW'(1) : fill_base;
  assign wptr_inc  = (wptr_r == LAST_SLOT) ? '0 : wptr_r + AW'(1);
  assign wptr_prev = (wptr_r == '0) ? LAST_SLOT : wptr_r - AW'(1);
  assign rd_prev   = (rd_addr_r == '0) ? LAST_SLOT : rd_addr_r - AW'(1);
  assign rd_en     = cmd.step && (left_r != '0);

  assign sts.need_result = (fill_nxt >= eff_k);
  assign sts.scan_done   = (left_r == '0) && !pend_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= rd_en;
      if (cmd.take) begin
        wptr_r <= wptr_inc;
        fill_r <= fill_nxt;
        if (sts.need_result) begin
          left_r <= eff_k - CW'(1);
        end
      end else if (rd_en) begin
        left_r <= left_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wptr_r] <= in_item.sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lo_r      <= in_item.sample;
      hi_r      <= in_item.sample;
      rd_addr_r <= wptr_prev;
    end else begin
      if (rd_en) begin
        rd_addr_r <= rd_prev;
      end
      if (pend_r) begin
        if (rd_data_r < lo_r) begin
          lo_r <= rd_data_r;
        end
        if (rd_data_r > hi_r) begin
          hi_r <= rd_data_r;
        end
      end
    end
    if (cmd.load_out) begin
      out_item_r.window_min <= lo_r;
      out_item_r.window_max <= hi_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// swmm_ctrl
// Controller: takes one sample and, when it completes a window, runs the
// window scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module swmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swmm_pkg::dp_sts_t sts,
  output swmm_pkg::dp_cmd_t cmd
);
  import swmm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && sts.need_result) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done && sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

FILE: rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Min and max of the last window_size signed samples of a stream.
// A sample that yields no result does not stall the input. With a result the
// input is stalled while the single read port of the ring scans the rest of
// the effective window, one sample per cycle; a stalled result slot holds
// the input stall until the slot is free. out_valid rises once the scan is
// done and the result is loaded into the output register.
// Synchronous reset clears fill count, write pointer and window_size (to 1);
// the ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  swmm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output swmm_pkg::out_item_t                 out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swmm_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [swmm_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [swmm_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import swmm_pkg::*;

  logic [WIN_SIZE_BITS-1:0] window_size_r;
  logic                     cfg_wr;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ADDR_WINDOW_SIZE) ? CFG_DATA_BITS'(window_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_wr && (paddr == ADDR_WINDOW_SIZE)) begin
      window_size_r <= pwdata[WIN_SIZE_BITS-1:0];
    end
  end

  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .window_size (window_size_r),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a scan");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.need_result) |=> in_stall)
    else $error("input taken during a scan");

endmodule
